>>> src/icmp_probe_reply_matcher_assert.svh
// Assertion macros shared by the ICMP probe reply matcher RTL.
// Depends on nothing; included by the modules that carry assertions.
`ifndef ICMP_PROBE_REPLY_MATCHER_ASSERT_SVH
`define ICMP_PROBE_REPLY_MATCHER_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define IPRM_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("icmp_prm: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define IPRM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("icmp_prm: next-cycle check failed");

`endif

>>> src/icmp_prm_pkg.sv
// Shared types and constants for the ICMP probe reply matcher.
// No dependencies; used by icmp_prm_parser and icmp_probe_reply_matcher.
`default_nettype none

package icmp_prm_pkg;

    // ICMP message types.
    localparam logic [7:0] TYPE_ECHO_REPLY    = 8'd0;
    localparam logic [7:0] TYPE_ECHO_REQUEST  = 8'd8;
    localparam logic [7:0] TYPE_TIME_EXCEEDED = 8'd11;

    // Match kinds reported with each packet.
    localparam logic [1:0] MATCH_NONE = 2'd0;
    localparam logic [1:0] MATCH_HOP  = 2'd1;
    localparam logic [1:0] MATCH_DEST = 2'd2;

    // Configuration register indexes.
    localparam logic CFG_PROBE_ID       = 1'b0;
    localparam logic CFG_PROBE_SEQUENCE = 1'b1;

    // Header layout. IHL counts 32-bit words, hence the shift by two.
    localparam int unsigned HDR_WORD_SHIFT    = 2;
    localparam logic [7:0]  SRC_ADDR_FIRST    = 8'd12;
    localparam logic [7:0]  SRC_ADDR_LAST     = 8'd15;
    localparam logic [7:0]  ICMP_QUOTE_OFFSET = 8'd8;
    localparam logic [7:0]  ICMP_ID_OFFSET    = 8'd4;
    localparam logic [7:0]  ICMP_SEQ_OFFSET   = 8'd6;
    localparam logic [7:0]  ICMP_END_OFFSET   = 8'd7;
    localparam logic [7:0]  BYTE_POS_MAX      = 8'd255;

    typedef struct packed {
        logic [1:0]  match_kind;
        logic [31:0] source_address;
    } t_result;

endpackage

`default_nettype wire

>>> src/icmp_probe_reply_matcher.sv
// Top level of the ICMP probe reply matcher: input register, parser and
// result register. Depends on icmp_prm_pkg, icmp_prm_parser and the assert header.
//
//  Channel   Signals                                   Direction
//  in        i_in_valid/o_in_ready, data, last         byte stream in
//  out       o_out_valid/i_out_ready, kind, address    one item per packet
//  cfg       i_cfg_we, i_cfg_index, i_cfg_data         register writes
//
// One byte item is taken per cycle while no last byte waits in the input register;
// the parser runs on the registered byte. A result appears in the output register
// at the edge at which the last byte leaves the input register.
// Only a last byte can wait in the input register, and only while the
// output register still holds an untaken result. Reset is synchronous.
`default_nettype none
`include "icmp_probe_reply_matcher_assert.svh"

module icmp_probe_reply_matcher (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic [7:0]  i_data_byte,
    input  wire logic        i_last_byte,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic [1:0]       o_match_kind,
    output logic [31:0]      o_source_address,
    input  wire logic        i_cfg_we,
    input  wire logic        i_cfg_index,
    input  wire logic [15:0] i_cfg_data
);

    logic [15:0] r_probe_id;
    logic [15:0] r_probe_sequence;

    logic        r_in_valid;
    logic [7:0]  r_in_data;
    logic        r_in_last;

    logic        r_out_valid;
    logic [1:0]  r_match_kind;
    logic [31:0] r_source_address;

    logic                  w_advance;
    icmp_prm_pkg::t_result w_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_probe_id       <= '0;
            r_probe_sequence <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                icmp_prm_pkg::CFG_PROBE_ID:       r_probe_id       <= i_cfg_data;
                icmp_prm_pkg::CFG_PROBE_SEQUENCE: r_probe_sequence <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // A byte leaves the input register unless it ends a packet whose result
    // would overwrite one still waiting to be taken.
    assign w_advance  = r_in_valid && (!r_in_last || !r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || w_advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_data <= i_data_byte;
            r_in_last <= i_last_byte;
        end
    end

    icmp_prm_parser u_parser (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_step           (w_advance),
        .i_data_byte      (r_in_data),
        .i_last_byte      (r_in_last),
        .i_probe_id       (r_probe_id),
        .i_probe_sequence (r_probe_sequence),
        .o_result         (w_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance && r_in_last) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance && r_in_last) begin
            r_match_kind     <= w_result.match_kind;
            r_source_address <= w_result.source_address;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_match_kind     = r_match_kind;
    assign o_source_address = r_source_address;

    `IPRM_ASSERT_NOW(a_mid_packet_never_stalls, i_clk, i_rst_n, r_in_valid && !r_in_last, w_advance)
    `IPRM_ASSERT_NOW(a_backpressure_only_on_last, i_clk, i_rst_n, !o_in_ready, r_in_valid && r_in_last && r_out_valid && !i_out_ready)
    `IPRM_ASSERT_NEXT(a_no_result_mid_packet, i_clk, i_rst_n, !r_out_valid && !(w_advance && r_in_last), !r_out_valid)
    `IPRM_ASSERT_NOW(a_no_match_zero_address, i_clk, i_rst_n, r_out_valid && r_match_kind == icmp_prm_pkg::MATCH_NONE, r_source_address == 32'd0)
    `IPRM_ASSERT_NOW(a_kind_in_range, i_clk, i_rst_n, r_out_valid, r_match_kind == icmp_prm_pkg::MATCH_NONE || r_match_kind == icmp_prm_pkg::MATCH_HOP || r_match_kind == icmp_prm_pkg::MATCH_DEST)

endmodule

`default_nettype wire

>>> src/icmp_prm_parser.sv
// Per-packet header parser: tracks byte position and captures the fields
// needed to classify an ICMP reply. Depends on icmp_prm_pkg.
`default_nettype none

module icmp_prm_parser (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_step,
    input  wire logic [7:0]            i_data_byte,
    input  wire logic                  i_last_byte,
    input  wire logic [15:0]           i_probe_id,
    input  wire logic [15:0]           i_probe_sequence,
    output icmp_prm_pkg::t_result      o_result
);

    logic [7:0]  r_byte_position, n_byte_position;
    logic [5:0]  r_outer_hlen,    n_outer_hlen;
    logic [5:0]  r_inner_hlen,    n_inner_hlen;
    logic [31:0] r_sender_addr,   n_sender_addr;
    logic [7:0]  r_outer_type,    n_outer_type;
    logic [7:0]  r_inner_type,    n_inner_type;
    logic [15:0] r_seen_id,       n_seen_id;
    logic [15:0] r_seen_seq,      n_seen_seq;

    logic        w_exceeded;
    logic [7:0]  w_icmp_start;
    logic [7:0]  w_icmp_end;
    logic [7:0]  w_need;
    logic        w_probe_ok;
    logic [1:0]  w_kind;

    always_comb begin
        // Header length from the first byte is used by this same byte.
        n_outer_hlen = (r_byte_position == 8'd0)
                     ? 6'(i_data_byte[3:0]) << icmp_prm_pkg::HDR_WORD_SHIFT
                     : r_outer_hlen;

        n_sender_addr = r_sender_addr;
        if (r_byte_position >= icmp_prm_pkg::SRC_ADDR_FIRST &&
            r_byte_position <= icmp_prm_pkg::SRC_ADDR_LAST) begin
            n_sender_addr = {r_sender_addr[23:0], i_data_byte};
        end

        n_outer_type = (r_byte_position == 8'(n_outer_hlen)) ? i_data_byte : r_outer_type;
        w_exceeded   = (n_outer_type == icmp_prm_pkg::TYPE_TIME_EXCEEDED);

        n_inner_hlen = r_inner_hlen;
        n_inner_type = r_inner_type;
        if (w_exceeded) begin
            if (r_byte_position == 8'(n_outer_hlen) + icmp_prm_pkg::ICMP_QUOTE_OFFSET) begin
                n_inner_hlen = 6'(i_data_byte[3:0]) << icmp_prm_pkg::HDR_WORD_SHIFT;
            end
            w_icmp_start = 8'(n_outer_hlen) + icmp_prm_pkg::ICMP_QUOTE_OFFSET
                         + 8'(n_inner_hlen);
            if (r_byte_position == w_icmp_start) begin
                n_inner_type = i_data_byte;
            end
        end else begin
            w_icmp_start = 8'(n_outer_hlen);
        end

        n_seen_id = r_seen_id;
        if (r_byte_position == w_icmp_start + icmp_prm_pkg::ICMP_ID_OFFSET ||
            r_byte_position == w_icmp_start + icmp_prm_pkg::ICMP_ID_OFFSET + 8'd1) begin
            n_seen_id = {r_seen_id[7:0], i_data_byte};
        end
        n_seen_seq = r_seen_seq;
        if (r_byte_position == w_icmp_start + icmp_prm_pkg::ICMP_SEQ_OFFSET ||
            r_byte_position == w_icmp_start + icmp_prm_pkg::ICMP_SEQ_OFFSET + 8'd1) begin
            n_seen_seq = {r_seen_seq[7:0], i_data_byte};
        end

        n_byte_position = (r_byte_position == icmp_prm_pkg::BYTE_POS_MAX)
                        ? r_byte_position : r_byte_position + 8'd1;

        // A packet must reach both the source address and the echo fields.
        w_icmp_end = w_icmp_start + icmp_prm_pkg::ICMP_END_OFFSET;
        w_need     = (w_icmp_end < icmp_prm_pkg::SRC_ADDR_LAST)
                   ? icmp_prm_pkg::SRC_ADDR_LAST : w_icmp_end;
        w_probe_ok = (r_byte_position >= w_need) && (n_seen_id == i_probe_id)
                   && (n_seen_seq == i_probe_sequence);

        w_kind = icmp_prm_pkg::MATCH_NONE;
        if (w_probe_ok) begin
            if (w_exceeded) begin
                if (n_inner_type == icmp_prm_pkg::TYPE_ECHO_REQUEST) begin
                    w_kind = icmp_prm_pkg::MATCH_HOP;
                end
            end else if (n_outer_type == icmp_prm_pkg::TYPE_ECHO_REPLY) begin
                w_kind = icmp_prm_pkg::MATCH_DEST;
            end
        end

        o_result.match_kind     = w_kind;
        o_result.source_address = (w_kind != icmp_prm_pkg::MATCH_NONE) ? n_sender_addr : 32'd0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_step && i_last_byte)) begin
            r_byte_position <= '0;
            r_outer_hlen    <= '0;
            r_inner_hlen    <= '0;
            r_sender_addr   <= '0;
            r_outer_type    <= '0;
            r_inner_type    <= '0;
            r_seen_id       <= '0;
            r_seen_seq      <= '0;
        end else if (i_step) begin
            r_byte_position <= n_byte_position;
            r_outer_hlen    <= n_outer_hlen;
            r_inner_hlen    <= n_inner_hlen;
            r_sender_addr   <= n_sender_addr;
            r_outer_type    <= n_outer_type;
            r_inner_type    <= n_inner_type;
            r_seen_id       <= n_seen_id;
            r_seen_seq      <= n_seen_seq;
        end
    end

endmodule

`default_nettype wire

>>> verif/tb_top.sv
`timescale 1ns / 100ps
// Testbench for icmp_probe_reply_matcher: packets are sent a byte per item,
// each result is checked against a parser model kept in step with the stream.
// Depends on icmp_prm_pkg and the RTL under src.

module tb_top;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    logic [7:0]  i_data_byte = 8'd0;
    logic        i_last_byte = 1'b0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    logic [1:0]  o_match_kind;
    logic [31:0] o_source_address;
    logic        i_cfg_we = 1'b0;
    logic        i_cfg_index = icmp_prm_pkg::CFG_PROBE_ID;
    logic [15:0] i_cfg_data = 16'd0;

    icmp_probe_reply_matcher uut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_data_byte      (i_data_byte),
        .i_last_byte      (i_last_byte),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_match_kind     (o_match_kind),
        .o_source_address (o_source_address),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Probe registers as the block should hold them.
    logic [15:0] probe_id_reg = 16'd0;
    logic [15:0] probe_seq_reg = 16'd0;

    // Per-packet parser state.
    logic [7:0]  byte_pos = 8'd0;
    logic [5:0]  outer_len = 6'd0;
    logic [5:0]  inner_len = 6'd0;
    logic [31:0] src_addr = 32'd0;
    logic [7:0]  outer_type = 8'd0;
    logic [7:0]  inner_type = 8'd0;
    logic [15:0] seen_id = 16'd0;
    logic [15:0] seen_seq = 16'd0;

    icmp_prm_pkg::t_result predicted_results[$];
    logic [7:0]  pkt_bytes[$];

    int  fail_count = 0;
    int  packet_count = 0;
    int  byte_count = 0;
    int  dest_matches = 0;
    int  hop_matches = 0;
    int  rejected = 0;
    int  stall_left = 0;
    bit  send_gaps = 1'b0;
    bit  recv_stalls = 1'b0;
    icmp_prm_pkg::t_result got_expected;

    // Follows one accepted byte through the header walk; the last byte of a
    // packet yields one predicted result and clears the packet state.
    task automatic parse_byte(input logic [7:0] b, input logic last);
        int p, h, ic, need;
        bit exceeded;
        icmp_prm_pkg::t_result r;
        p = byte_pos;
        if (p == 0)
            outer_len = {b[3:0], 2'b00};
        h = outer_len;
        if (p >= 12 && p <= 15)
            src_addr = {src_addr[23:0], b};
        if (p == h)
            outer_type = b;
        exceeded = (outer_type == icmp_prm_pkg::TYPE_TIME_EXCEEDED);
        if (exceeded) begin
            if (p == h + 8)
                inner_len = {b[3:0], 2'b00};
            ic = h + 8 + int'(inner_len);
            if (p == ic)
                inner_type = b;
        end else begin
            ic = h;
        end
        if (p == ic + 4 || p == ic + 5)
            seen_id = {seen_id[7:0], b};
        if (p == ic + 6 || p == ic + 7)
            seen_seq = {seen_seq[7:0], b};
        byte_pos = (p < 255) ? 8'(p + 1) : 8'd255;
        byte_count++;
        if (last) begin
            need = (ic + 7 < 15) ? 15 : ic + 7;
            r.match_kind = icmp_prm_pkg::MATCH_NONE;
            if (p >= need && seen_id == probe_id_reg && seen_seq == probe_seq_reg) begin
                if (exceeded) begin
                    if (inner_type == icmp_prm_pkg::TYPE_ECHO_REQUEST)
                        r.match_kind = icmp_prm_pkg::MATCH_HOP;
                end else if (outer_type == icmp_prm_pkg::TYPE_ECHO_REPLY) begin
                    r.match_kind = icmp_prm_pkg::MATCH_DEST;
                end
            end
            r.source_address = (r.match_kind != icmp_prm_pkg::MATCH_NONE) ? src_addr : 32'd0;
            predicted_results.push_back(r);
            byte_pos = 8'd0;
            outer_len = 6'd0;
            inner_len = 6'd0;
            src_addr = 32'd0;
            outer_type = 8'd0;
            inner_type = 8'd0;
            seen_id = 16'd0;
            seen_seq = 16'd0;
        end
    endtask

    // Presents one item and holds it until the block takes it.
    task automatic send_byte(input logic [7:0] b, input logic last);
        i_in_valid <= 1'b1;
        i_data_byte <= b;
        i_last_byte <= last;
        @(posedge i_clk);
        while (!o_in_ready)
            @(posedge i_clk);
        parse_byte(b, last);
        if (send_gaps && $urandom_range(0, 5) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge i_clk);
        end
    endtask

    task automatic send_packet();
        for (int i = 0; i < pkt_bytes.size(); i++)
            send_byte(pkt_bytes[i], i == pkt_bytes.size() - 1);
        packet_count++;
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        do
            @(posedge i_clk);
        while (predicted_results.size() != 0);
    endtask

    // Registers are only written once the parser is idle.
    task automatic set_probe(input logic [15:0] id, input logic [15:0] seq);
        wait_drained();
        repeat (4) @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= icmp_prm_pkg::CFG_PROBE_ID;
        i_cfg_data <= id;
        @(posedge i_clk);
        i_cfg_index <= icmp_prm_pkg::CFG_PROBE_SEQUENCE;
        i_cfg_data <= seq;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        probe_id_reg = id;
        probe_seq_reg = seq;
    endtask

    // Lays out an outer header, the ICMP header and, for a time-exceeded
    // message, the quoted inner header. Later fields win where a short header
    // makes them overlap.
    task automatic build_packet(input bit hop, input logic [3:0] ihl,
                                input logic [3:0] inner_ihl, input logic [7:0] msg_type,
                                input logic [15:0] id, input logic [15:0] seq,
                                input int extra, input logic [31:0] src);
        int h, ic, total;
        h = int'(ihl) * 4;
        ic = hop ? h + 8 + int'(inner_ihl) * 4 : h;
        total = ic + 8 + extra;
        pkt_bytes.delete();
        repeat (total) pkt_bytes.push_back(8'($urandom));
        pkt_bytes[0] = {4'($urandom), ihl};
        for (int k = 0; k < 4; k++)
            if (12 + k < total)
                pkt_bytes[12 + k] = src[31 - 8 * k -: 8];
        if (hop) begin
            pkt_bytes[h] = icmp_prm_pkg::TYPE_TIME_EXCEEDED;
            pkt_bytes[h + 8] = {4'h4, inner_ihl};
        end
        pkt_bytes[ic] = msg_type;
        pkt_bytes[ic + 4] = id[15:8];
        pkt_bytes[ic + 5] = id[7:0];
        pkt_bytes[ic + 6] = seq[15:8];
        pkt_bytes[ic + 7] = seq[7:0];
    endtask

    task automatic cut_packet(input int keep);
        while (pkt_bytes.size() > keep)
            void'(pkt_bytes.pop_back());
    endtask

    // Mostly well-formed replies with random content; the rest are wrong ids,
    // truncated packets, odd types, long packets and plain noise.
    task automatic make_random_packet();
        int sel;
        bit hop;
        logic [3:0] ihl, inner_ihl;
        logic [7:0] msg_type;
        logic [15:0] id, seq;
        sel = $urandom_range(0, 99);
        if (sel < 10) begin
            pkt_bytes.delete();
            repeat ($urandom_range(1, 48)) pkt_bytes.push_back(8'($urandom));
            return;
        end
        hop = 1'($urandom_range(0, 1));
        ihl = ($urandom_range(0, 4) != 0) ? 4'd5 : 4'($urandom);
        inner_ihl = ($urandom_range(0, 4) != 0) ? 4'd5 : 4'($urandom);
        if ($urandom_range(0, 5) == 0)
            msg_type = 8'($urandom);
        else
            msg_type = hop ? icmp_prm_pkg::TYPE_ECHO_REQUEST : icmp_prm_pkg::TYPE_ECHO_REPLY;
        id = probe_id_reg;
        seq = probe_seq_reg;
        if (sel < 25) begin
            case ($urandom_range(0, 2))
                0: id ^= 16'(1 << $urandom_range(0, 15));
                1: seq ^= 16'(1 << $urandom_range(0, 15));
                default: begin
                    id = 16'($urandom);
                    seq = 16'($urandom);
                end
            endcase
        end
        build_packet(hop, ihl, inner_ihl, msg_type, id, seq,
                     (sel >= 95) ? $urandom_range(150, 300) : $urandom_range(0, 12),
                     $urandom);
        if (sel >= 25 && sel < 37 && pkt_bytes.size() > 1)
            cut_packet($urandom_range(1, pkt_bytes.size() - 1));
    endtask

    function automatic logic [15:0] pick_probe();
        case ($urandom_range(0, 3))
            0: return 16'h0000;
            1: return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic test_echo_reply();
        // Probe registers are still at their reset value of zero here.
        build_packet(1'b0, 4'd5, 4'd5, icmp_prm_pkg::TYPE_ECHO_REPLY, 16'h0000, 16'h0000, 0,
                     32'hFFFF_FFFF);
        send_packet();
        set_probe(16'hFFFF, 16'hFFFF);
        build_packet(1'b0, 4'd5, 4'd5, icmp_prm_pkg::TYPE_ECHO_REPLY, 16'hFFFF, 16'hFFFF, 4,
                     32'h0);
        send_packet();
        build_packet(1'b0, 4'd5, 4'd5, icmp_prm_pkg::TYPE_ECHO_REPLY, 16'hFFFF, 16'hFFFE, 2,
                     32'h0A00_0001);
        send_packet();
        build_packet(1'b0, 4'd5, 4'd5, icmp_prm_pkg::TYPE_ECHO_REQUEST, 16'hFFFF, 16'hFFFF, 0,
                     32'hC0A8_0101);
        send_packet();
        wait_drained();
    endtask

    task automatic test_time_exceeded();
        set_probe(16'hA5C3, 16'h5A3C);
        build_packet(1'b1, 4'd6, 4'd7, icmp_prm_pkg::TYPE_ECHO_REQUEST, 16'hA5C3, 16'h5A3C, 3,
                     32'h8080_0101);
        send_packet();
        build_packet(1'b1, 4'd5, 4'd5, icmp_prm_pkg::TYPE_ECHO_REPLY, 16'hA5C3, 16'h5A3C, 0,
                     32'h0102_0304);
        send_packet();
        build_packet(1'b1, 4'd5, 4'd5, icmp_prm_pkg::TYPE_ECHO_REQUEST, 16'hA5C2, 16'h5A3C, 0,
                     32'h0102_0304);
        send_packet();
        wait_drained();
    endtask

    task automatic test_short_packets();
        // Packets that stop before the address ends or before the sequence ends.
        build_packet(1'b0, 4'd5, 4'd5, icmp_prm_pkg::TYPE_ECHO_REPLY, 16'hA5C3, 16'h5A3C, 0,
                     32'h1111_2222);
        cut_packet(27);
        send_packet();
        build_packet(1'b0, 4'd5, 4'd5, icmp_prm_pkg::TYPE_ECHO_REPLY, 16'hA5C3, 16'h5A3C, 0,
                     32'h1111_2222);
        cut_packet(15);
        send_packet();
        cut_packet(1);
        send_packet();
        wait_drained();
    endtask

    task automatic test_small_ihl();
        // With a zero header length the ICMP header sits on top of the IP header.
        build_packet(1'b0, 4'd0, 4'd5, icmp_prm_pkg::TYPE_ECHO_REPLY, 16'hA5C3, 16'h5A3C, 8,
                     32'hDEAD_BEEF);
        send_packet();
        build_packet(1'b0, 4'd3, 4'd5, icmp_prm_pkg::TYPE_ECHO_REPLY, 16'hA5C3, 16'h5A3C, 1,
                     32'h0000_00FF);
        send_packet();
        build_packet(1'b1, 4'd5, 4'd1, icmp_prm_pkg::TYPE_ECHO_REQUEST, 16'hA5C3, 16'h5A3C, 0,
                     32'h7F00_0001);
        send_packet();
        wait_drained();
    endtask

    task automatic test_long_packet();
        // The byte position saturates well past every field of interest.
        build_packet(1'b1, 4'd15, 4'd15, icmp_prm_pkg::TYPE_ECHO_REQUEST, 16'hA5C3, 16'h5A3C,
                     130, 32'hFEDC_BA98);
        send_packet();
        wait_drained();
    endtask

    task automatic test_random_traffic();
        int packets, bytes;
        packets = 0;
        bytes = 0;
        while (bytes < 250) begin
            if (packets % 4 == 3)
                set_probe(pick_probe(), pick_probe());
            send_gaps = ($urandom_range(0, 3) != 0);
            recv_stalls = ($urandom_range(0, 3) != 0);
            make_random_packet();
            bytes += pkt_bytes.size();
            send_packet();
            packets++;
        end
        wait_drained();
    endtask

    task automatic test_steady_stream();
        send_gaps = 1'b0;
        recv_stalls = 1'b0;
        set_probe(16'($urandom), 16'($urandom));
        repeat (3) begin
            make_random_packet();
            send_packet();
        end
        wait_drained();
    endtask

    // Receiver side: random stall bursts while enabled.
    always @(posedge i_clk) begin
        if (stall_left != 0) begin
            i_out_ready <= 1'b0;
            stall_left <= stall_left - 1;
        end else if (recv_stalls && $urandom_range(0, 7) == 0) begin
            i_out_ready <= 1'b0;
            stall_left <= $urandom_range(0, 13);
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (predicted_results.size() == 0) begin
                $error("result with no packet outstanding: match_kind %0d source_address %h",
                       o_match_kind, o_source_address);
                fail_count++;
            end else begin
                got_expected = predicted_results.pop_front();
                if (o_match_kind !== got_expected.match_kind) begin
                    $error("match_kind: expected %0d, got %0d",
                           got_expected.match_kind, o_match_kind);
                    fail_count++;
                end
                if (o_source_address !== got_expected.source_address) begin
                    $error("source_address: expected %h, got %h",
                           got_expected.source_address, o_source_address);
                    fail_count++;
                end
                case (got_expected.match_kind)
                    icmp_prm_pkg::MATCH_DEST: dest_matches++;
                    icmp_prm_pkg::MATCH_HOP:  hop_matches++;
                    default:                  rejected++;
                endcase
            end
        end
    end

    initial begin
        #20_000_000;
        $display("TB_ERROR");
        $finish;
    end

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        send_gaps = 1'b1;
        recv_stalls = 1'b1;
        test_echo_reply();
        test_time_exceeded();
        test_short_packets();
        test_small_ihl();
        test_long_packet();
        test_random_traffic();
        test_steady_stream();
        repeat (8) @(posedge i_clk);
        $display("Sent %0d packets in %0d bytes under several probe settings.",
                 packet_count, byte_count);
        $display("Replies from destination: %0d, from hops: %0d, not ours: %0d.",
                 dest_matches, hop_matches, rejected);
        if (fail_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
